>>> src/aes256_cbc_block_cipher_defines.svh
// Assertion macros for the AES-256 CBC block.
// No dependencies.
`ifndef AES256_CBC_BLOCK_CIPHER_DEFINES_SVH
`define AES256_CBC_BLOCK_CIPHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define AES_ASSERT_IMP(lbl, clk, rstn, a, c)
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

>>> src/aes_pkg.sv
// Package for the AES-256 CBC block: types, tables and round functions.
// No dependencies.
package aes_pkg;
    localparam int ROUNDS = 14;
    localparam int STORE_DEPTH = 2 * (ROUNDS + 1);
    localparam int KEY_WORDS = 8;
    localparam int SCHED_WORDS = 4 * (ROUNDS + 1);
    localparam int RK_AW = $clog2(ROUNDS + 1);
    localparam int WIDX_W = $clog2(SCHED_WORDS + 1);
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IV_HI = 3'd4;
    localparam logic [2:0] REG_IV_LO = 3'd5;
    localparam logic KIND_ENC = 1'b0;

    typedef struct packed {
        logic        kind;
        logic        restart_chain;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } in_req_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } out_req_t;

    typedef struct packed {
        logic             start;
        logic             busy;
        logic             done;
    } ks_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte n of the block is bits [127-8n -: 8].
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = INV_SBOX[s[127 - 8 * (4 * c + r) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                a[r] = s[127 - 8 * (4 * c + r) -: 8];
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4])
                    ^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r] = s[127 - 8 * (4 * c + r) -: 8];
                x2[r] = xtime(a[r]);
                x4[r] = xtime(x2[r]);
                x8[r] = xtime(x4[r]);
            end
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r])
                    ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                    ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
                    ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
        end
        return t;
    endfunction
endpackage

>>> src/aes256_cbc_block_cipher.sv
// AES-256 CBC block: one request at a time, one round per cycle in the shared round
// unit. After a key write the first request also waits for the key expansion, one word
// per cycle. No new request is taken until the result of the last one has been handed over.
// Reset clears the chain value, key and IV registers and marks the keys stale.
`include "aes256_cbc_block_cipher_defines.svh"
module aes256_cbc_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_req_t    out_data
);
    typedef enum logic [2:0] { S_IDLE, S_KEYS, S_KWAIT, S_RUN, S_OUT } state_t;
    state_t state_reg;
    logic [255:0] key_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg;
    logic         stale_reg;
    in_req_t      req_reg;
    out_req_t     out_reg;
    logic         out_valid_reg;
    logic         ks_start;
    logic         core_start;
    logic [RK_AW-1:0] rk_round;
    logic [127:0] rk;
    logic [127:0] core_res;
    logic         core_done;
    logic [127:0] chain_use;
    ks_ctrl_t     ks_ctrl;

    assign in_ready  = state_reg == S_IDLE;
    assign ks_start  = (state_reg == S_IDLE && in_valid && stale_reg);
    assign chain_use = req_reg.restart_chain ? iv_reg : chain_reg;
    assign core_start = state_reg == S_KWAIT
        || (state_reg == S_KEYS && ks_ctrl.done);

    aes_key_sched u_keys (
        .clk(clk), .rst_n(rst_n), .start(ks_start), .key(key_reg),
        .rd_round(rk_round), .rd_key(rk), .ctrl(ks_ctrl)
    );

    aes_round_core u_core (
        .clk(clk), .rst_n(rst_n), .start(core_start), .kind(req_reg.kind),
        .data(req_reg.kind == KIND_ENC ? {req_reg.block_hi, req_reg.block_lo} ^ chain_use
                                       : {req_reg.block_hi, req_reg.block_lo}),
        .rkey(rk), .rk_round(rk_round), .done(core_done), .result(core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= '0;
            iv_reg        <= '0;
            chain_reg     <= '0;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY0: begin key_reg[255:192] <= cfg_data; stale_reg <= 1'b1; end
                    REG_KEY1: begin key_reg[191:128] <= cfg_data; stale_reg <= 1'b1; end
                    REG_KEY2: begin key_reg[127:64]  <= cfg_data; stale_reg <= 1'b1; end
                    REG_KEY3: begin key_reg[63:0]    <= cfg_data; stale_reg <= 1'b1; end
                    REG_IV_HI: iv_reg[127:64] <= cfg_data;
                    REG_IV_LO: iv_reg[63:0]   <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= stale_reg ? S_KEYS : S_KWAIT;
                        stale_reg <= 1'b0;
                    end
                end
                S_KEYS:
                    if (ks_ctrl.done)
                        state_reg <= S_RUN;
                S_KWAIT:
                    state_reg <= S_RUN;
                S_RUN:
                begin
                    if (core_done)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                        if (req_reg.kind == KIND_ENC)
                            chain_reg <= core_res;
                        else
                            chain_reg <= {req_reg.block_hi, req_reg.block_lo};
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        if (state_reg == S_RUN && core_done)
        begin
            if (req_reg.kind == KIND_ENC)
                out_reg <= core_res;
            else
                out_reg <= core_res ^ chain_use;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `AES_ASSERT_IMP(a_ready_not_busy, clk, rst_n, in_ready, !out_valid_reg && !ks_ctrl.busy)
    `AES_ASSERT_NEXT(a_done_to_out, clk, rst_n, state_reg == S_RUN && core_done, out_valid_reg)
    `AES_ASSERT_IMP(a_keys_busy, clk, rst_n, state_reg == S_RUN, !ks_ctrl.busy)
endmodule

>>> src/aes_key_sched.sv
// Key expansion sequencer and round key store for the AES-256 CBC block.
// Depends on aes_pkg; one schedule word is produced per cycle while the expansion is busy.
module aes_key_sched
    import aes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [255:0]     key,
    input  logic [RK_AW-1:0] rd_round,
    output logic [127:0]     rd_key,
    output ks_ctrl_t         ctrl
);
    logic [127:0] store [ROUNDS + 1];
    logic [31:0]  win_reg [KEY_WORDS];
    logic [WIDX_W-1:0] idx_reg;
    logic [7:0]   rcon_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  t;
    logic [31:0]  nw;

    always_comb
    begin
        t = win_reg[KEY_WORDS - 1];
        if (idx_reg[2:0] == 3'd0)
            t = sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        else if (idx_reg[2:0] == 3'd4)
            t = sub_word(t);
        nw = win_reg[0] ^ t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= WIDX_W'(KEY_WORDS);
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            if (idx_reg[2:0] == 3'd0)
                rcon_reg <= xtime(rcon_reg);
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == WIDX_W'(SCHED_WORDS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
                win_reg[i] <= key[255 - 32 * i -: 32];
            store[0] <= key[255:128];
            store[1] <= key[127:0];
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < KEY_WORDS - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[KEY_WORDS - 1] <= nw;
            if (idx_reg[1:0] == 2'd3)
                store[idx_reg[WIDX_W-1:2]] <= {win_reg[KEY_WORDS - 3], win_reg[KEY_WORDS - 2],
                                               win_reg[KEY_WORDS - 1], nw};
        end
        rd_key <= store[rd_round];
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
endmodule

>>> src/aes_round_core.sv
// Shared round unit and sequencer for the AES-256 CBC block.
// Depends on aes_pkg and the defines header; one round per cycle.
`include "aes256_cbc_block_cipher_defines.svh"
module aes_round_core
    import aes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             kind,
    input  logic [127:0]     data,
    input  logic [127:0]     rkey,
    output logic [RK_AW-1:0] rk_round,
    output logic             done,
    output logic [127:0]     result
);
    typedef enum logic [1:0] { S_IDLE, S_FIRST, S_ROUND } state_t;
    state_t state_reg;
    logic [127:0] st_reg;
    logic [RK_AW-1:0] rnd_reg;
    logic kind_reg;
    logic done_reg;
    logic [127:0] enc_v;
    logic [127:0] dec_v;
    logic last;

    assign last = kind_reg == KIND_ENC ? (rnd_reg == RK_AW'(ROUNDS)) : (rnd_reg == '0);
    // The store registers the key in the cycle after its index is shown.
    assign rk_round = state_reg == S_IDLE ? (kind == KIND_ENC ? '0 : RK_AW'(ROUNDS))
        : (kind_reg == KIND_ENC ? rnd_reg + 1'b1 : rnd_reg - 1'b1);

    always_comb
    begin
        enc_v = sub_shift(st_reg);
        if (rnd_reg != RK_AW'(ROUNDS))
            enc_v = mix(enc_v);
        enc_v = enc_v ^ rkey;
        dec_v = st_reg ^ rkey;
        if (rnd_reg != RK_AW'(ROUNDS) && rnd_reg != '0)
            dec_v = inv_mix(dec_v);
        if (rnd_reg != '0)
            dec_v = inv_sub_shift(dec_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg   <= '0;
            kind_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_FIRST;
                        kind_reg  <= kind;
                        rnd_reg   <= kind == KIND_ENC ? '0 : RK_AW'(ROUNDS);
                    end
                end
                S_FIRST:
                begin
                    state_reg <= S_ROUND;
                    rnd_reg   <= kind_reg == KIND_ENC ? rnd_reg + 1'b1 : rnd_reg - 1'b1;
                end
                S_ROUND:
                begin
                    if (last)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        rnd_reg <= kind_reg == KIND_ENC ? rnd_reg + 1'b1 : rnd_reg - 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            st_reg <= data;
        else if (state_reg == S_FIRST && kind_reg == KIND_ENC)
            st_reg <= st_reg ^ rkey;
        else if (state_reg != S_IDLE)
            st_reg <= kind_reg == KIND_ENC ? enc_v : dec_v;
    end

    assign done = done_reg;
    assign result = st_reg;

    `AES_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, state_reg == S_IDLE && start,
        state_reg == S_FIRST)
    `AES_ASSERT_IMP(a_round_in_range, clk, rst_n, state_reg != S_IDLE,
        rnd_reg <= RK_AW'(ROUNDS))
    `AES_ASSERT_NEXT(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE && !done_reg)
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the AES-256 CBC block cipher.
// Depends on aes_pkg and aes256_cbc_block_cipher; predicts each block in-house.
`timescale 1ns / 1ps
module tb_top;
    import aes_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_req_t     in_data;
    logic        out_valid;
    logic        out_ready;
    out_req_t    out_data;

    aes256_cbc_block_cipher dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1030;

    logic [7:0] fwd_box [256];
    logic [7:0] inv_box [256];
    logic [63:0] key_reg [4];
    logic [127:0] iv_reg;
    logic [127:0] chain_val;
    logic [127:0] sched [15];
    bit keys_stale;
    out_req_t expected_blocks [$];
    int errors;
    int accepted;
    int received;
    int cycles;
    bit hold_long;
    bit hold_done;

    typedef struct {
        logic        kind;
        logic        restart;
        logic [63:0] bhi;
        logic [63:0] blo;
        bit          known;
        logic [63:0] rhi;
        logic [63:0] rlo;
    } vec_row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input int m);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i])
                r ^= a;
            a = gf_double(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int n);
        return s[127 - 8 * n -: 8];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    task automatic build_boxes();
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] x;
        p = 8'h01;
        q = 8'h01;
        fwd_box[0] = 8'h63;
        do
        begin
            p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7])
                q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]};
            fwd_box[p] = x ^ 8'h63;
        end
        while (p != 8'h01);
        for (int i = 0; i < 256; i++)
            inv_box[fwd_box[i]] = i[7:0];
    endtask

    function automatic void expand_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [31:0] rc;
        rc = 32'h01000000;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i - 1];
            if (i % 8 == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ rc;
                rc = {gf_double(rc[31:24]), 24'h0};
            end
            else if (i % 8 == 4)
                t = sbox_word(t);
            w[i] = w[i - 8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            sched[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        keys_stale = 1'b0;
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input bit with_mix);
        logic [127:0] t;
        logic [127:0] u;
        logic [7:0] a [4];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * c + r) -: 8] = fwd_box[byte_at(s, 4 * ((c + r) % 4) + r)];
        if (!with_mix)
            return t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
                a[r] = byte_at(t, 4 * c + r);
            for (int r = 0; r < 4; r++)
                u[127 - 8 * (4 * c + r) -: 8] = gf_mul(a[r], 2) ^ gf_mul(a[(r + 1) % 4], 3)
                    ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return u;
    endfunction

    function automatic logic [127:0] inv_round(input logic [127:0] s, input bit with_mix);
        logic [127:0] t;
        logic [127:0] u;
        logic [7:0] a [4];
        u = s;
        if (with_mix)
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                    a[r] = byte_at(s, 4 * c + r);
                for (int r = 0; r < 4; r++)
                    u[127 - 8 * (4 * c + r) -: 8] = gf_mul(a[r], 14)
                        ^ gf_mul(a[(r + 1) % 4], 11) ^ gf_mul(a[(r + 2) % 4], 13)
                        ^ gf_mul(a[(r + 3) % 4], 9);
            end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = inv_box[byte_at(u, 4 * c + r)];
        return t;
    endfunction

    function automatic out_req_t cipher_block(input in_req_t req);
        logic [127:0] s;
        logic [127:0] blk;
        out_req_t res;
        if (keys_stale)
            expand_keys();
        if (req.restart_chain)
            chain_val = iv_reg;
        blk = {req.block_hi, req.block_lo};
        if (req.kind == KIND_ENC)
        begin
            s = blk ^ chain_val ^ sched[0];
            for (int r = 1; r < 14; r++)
                s = fwd_round(s, 1'b1) ^ sched[r];
            s = fwd_round(s, 1'b0) ^ sched[14];
            chain_val = s;
        end
        else
        begin
            s = inv_round(blk ^ sched[14], 1'b0);
            for (int r = 13; r > 0; r--)
                s = inv_round(s ^ sched[r], 1'b1);
            s = s ^ sched[0] ^ chain_val;
            chain_val = blk;
        end
        res.result_hi = s[127:64];
        res.result_lo = s[63:0];
        return res;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
            begin
                key_reg[idx] = val;
                keys_stale = 1'b1;
            end
            REG_IV_HI: iv_reg[127:64] = val;
            REG_IV_LO: iv_reg[63:0] = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_blocks.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] ivh, input logic [63:0] ivl);
        wait_drained();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_IV_HI, ivh);
        write_reg(REG_IV_LO, ivl);
    endtask

    task automatic send_request(input in_req_t req);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        in_data = req;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_blocks.push_back(cipher_block(req));
        accepted++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0001;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        vec_row_t vectors [$];
        in_req_t req;
        out_req_t got;
        build_boxes();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        errors = 0;
        accepted = 0;
        received = 0;
        hold_long = 1'b0;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        iv_reg = '0;
        chain_val = '0;
        keys_stale = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vectors.push_back('{1'b0, 1'b1, 64'h0, 64'h0, 1'b1,
                            64'hdc95c078a2408989, 64'had48a21492842087});
        vectors.push_back('{1'b1, 1'b1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0});
        vectors.push_back('{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                            1'b0, 64'h0, 64'h0});
        vectors.push_back('{1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 64'h0, 64'h0});
        for (int i = 0; i < vectors.size(); i++)
        begin
            req = '{vectors[i].kind, vectors[i].restart, vectors[i].bhi, vectors[i].blo};
            send_request(req);
            got = expected_blocks[$];
            if (vectors[i].known && (got.result_hi != vectors[i].rhi
                                     || got.result_lo != vectors[i].rlo))
            begin
                $display("%0t table row %0d: expected %h%h, predicted %h%h", $time, i,
                         vectors[i].rhi, vectors[i].rlo, got.result_hi, got.result_lo);
                errors++;
            end
        end

        set_keys(64'h603deb1015ca71be, 64'h2b73aef0857d7781, 64'h1f352c073b6108d7,
                 64'h2d9810a30914dff4, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        vectors.delete();
        vectors.push_back('{1'b0, 1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1,
                            64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6});
        vectors.push_back('{1'b0, 1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b1,
                            64'h9cfc4e967edb808d, 64'h679f777bc6702c7d});
        vectors.push_back('{1'b1, 1'b1, 64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6, 1'b1,
                            64'h6bc1bee22e409f96, 64'he93d7e117393172a});
        vectors.push_back('{1'b1, 1'b0, 64'h9cfc4e967edb808d, 64'h679f777bc6702c7d, 1'b1,
                            64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51});
        for (int i = 0; i < vectors.size(); i++)
        begin
            req = '{vectors[i].kind, vectors[i].restart, vectors[i].bhi, vectors[i].blo};
            send_request(req);
            got = expected_blocks[$];
            if (got.result_hi != vectors[i].rhi || got.result_lo != vectors[i].rlo)
            begin
                $display("%0t known-answer row %0d: expected %h%h, predicted %h%h", $time,
                         i, vectors[i].rhi, vectors[i].rlo, got.result_hi, got.result_lo);
                errors++;
            end
        end
        wait_drained();
        write_reg(3'd6, rand64());
        write_reg(3'd7, rand64());
        write_reg(REG_IV_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        req = '{KIND_ENC, 1'b1, 64'h0, 64'h0};
        send_request(req);

        set_keys(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 8; i++)
        begin
            req = '{i[0], i[1], edge64(), edge64()};
            send_request(req);
        end

        hold_long = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            req = '{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand64(), rand64()};
            send_request(req);
        end
        hold_long = 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            set_keys(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                req = '{1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0), edge64(),
                        edge64()};
                send_request(req);
            end
        end
        wait_drained();
        $display("Covered %0d blocks in both directions under nine key settings,", accepted);
        $display("including chain restarts, extreme keys and blocks, and output stalls.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_long && !hold_done)
            begin
                out_ready = 1'b0;
                hold_done = 1'b1;
                repeat (150) @(negedge clk);
            end
            if ($urandom_range(0, 19) == 0)
                out_ready = 1'b0;
            else if ($urandom_range(0, 2) == 0)
                out_ready = ($urandom_range(0, 1) == 1);
            else
                out_ready = 1'b1;
            if (!out_ready && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(5, 40)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && out_ready)
        begin
            received++;
            if (expected_blocks.size() == 0)
            begin
                $display("%0t unexpected result %h%h", $time, out_data.result_hi,
                         out_data.result_lo);
                errors++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (want.result_hi !== out_data.result_hi)
                begin
                    $display("%0t result_hi: expected %h, actual %h", $time, want.result_hi,
                             out_data.result_hi);
                    errors++;
                end
                if (want.result_lo !== out_data.result_lo)
                begin
                    $display("%0t result_lo: expected %h, actual %h", $time, want.result_lo,
                             out_data.result_lo);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
                 expected_blocks.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> aes256_cbc_block_cipher.f
+incdir+src
src/aes_pkg.sv
src/aes_key_sched.sv
src/aes_round_core.sv
src/aes256_cbc_block_cipher.sv
tb/tb_top.sv
